// File: rtl/tcwi_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants for the tilt classifier.
// No dependencies; every other file but tcwi_if imports this package.
package tcwi_pkg;

  localparam int GROUP_SIZE = 12;   // samples per averaged group, 1 to 16
  localparam int SAMPLE_W   = 12;
  localparam int SUM_W      = 16;
  localparam int CNT_W      = 4;    // holds GROUP_SIZE - 1
  localparam int AVG_W      = 12;
  localparam int DUTY_W     = 10;
  localparam int QUEUE_DEPTH = 4;

  // Division by GROUP_SIZE as a multiply by a rounded-up reciprocal.
  // The error term stays below 2^(SUM_W + 4 - RECIP_SHIFT), well under 1/GROUP_SIZE.
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PROD_W      = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((1 << RECIP_SHIFT) / GROUP_SIZE + 1);

  localparam logic [DUTY_W-1:0] DUTY_LEFT   = 10'd31;
  localparam logic [DUTY_W-1:0] DUTY_CENTRE = 10'd47;
  localparam logic [DUTY_W-1:0] DUTY_RIGHT  = 10'd63;

  localparam logic [1:0] DIR_NONE  = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_RIGHT = 2'd2;
  localparam logic [1:0] DIR_FLAT  = 2'd3;

  localparam logic [1:0] TS_FLAT     = 2'd0;
  localparam logic [1:0] TS_LEFT     = 2'd1;
  localparam logic [1:0] TS_RIGHT    = 2'd2;
  localparam logic [1:0] TS_UNSTABLE = 2'd3;

  localparam logic [3:0] SWAP_MAX = 4'd15;

  typedef enum logic [2:0] {
    REG_LEFT_BELOW    = 3'd0,
    REG_RIGHT_ABOVE   = 3'd1,
    REG_FLAT_FLOOR    = 3'd2,
    REG_FLAT_CEILING  = 3'd3,
    REG_SWAPS_NEEDED  = 3'd4,
    REG_QUIET_LIMIT   = 3'd5,
    REG_INVERTED      = 3'd6
  } tcwi_reg_t;

  typedef struct packed {
    logic [12:0] left_below;
    logic [11:0] right_above;
    logic [11:0] flat_floor;
    logic [11:0] flat_ceiling;
    logic [3:0]  swaps_needed;
    logic [5:0]  quiet_limit;
    logic        inverted;
  } tcwi_cfg_t;

  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] sum;
  } tcwi_push_t;

endpackage

// File: rtl/tcwi_if.sv
`timescale 1ns / 1ps
// Stream interfaces for samples in and classified results out.
// No dependencies; field widths are written out as literals.
interface tcwi_sample_if;
  logic        valid;
  logic        ready;
  logic [11:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface tcwi_result_if;
  logic        valid;
  logic        ready;
  logic [11:0] average;
  logic [1:0]  tilt_state;
  logic [9:0]  servo_duty;
  modport source (output valid, output average, output tilt_state, output servo_duty,
                  input ready);
  modport sink (input valid, input average, input tilt_state, input servo_duty,
                output ready);
endinterface

// File: rtl/tcwi_front.sv
`timescale 1ns / 1ps
// Front end: accumulate samples and emit one group sum per GROUP_SIZE samples.
// Depends on tcwi_pkg.
module tcwi_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [tcwi_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                        queue_full,
  output logic                        in_ready,
  output tcwi_pkg::tcwi_push_t        push
);
  import tcwi_pkg::*;

  logic [SUM_W-1:0] sum_acc;
  logic [CNT_W-1:0] sample_count;
  logic [SUM_W-1:0] sum_next;
  logic [CNT_W:0]   count_inc;
  logic             accept;
  logic             group_end;

  assign in_ready  = !queue_full;
  assign accept    = in_valid && in_ready;
  assign sum_next  = sum_acc + SUM_W'(in_sample);
  assign count_inc = {1'b0, sample_count} + (CNT_W + 1)'(1);
  assign group_end = !(count_inc < (CNT_W + 1)'(GROUP_SIZE));

  assign push.valid = accept && group_end;
  assign push.sum   = sum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_acc      <= '0;
      sample_count <= '0;
    end else if (accept) begin
      if (group_end) begin
        sum_acc      <= '0;
        sample_count <= '0;
      end else begin
        sum_acc      <= sum_next;
        sample_count <= count_inc[CNT_W-1:0];
      end
    end
  end

endmodule

// File: rtl/tcwi_queue.sv
`timescale 1ns / 1ps
// Short FIFO of group sums between the front and back ends.
// Depends on tcwi_pkg.
module tcwi_queue (
  input  logic                     clk,
  input  logic                     rst,
  input  tcwi_pkg::tcwi_push_t     push,
  input  logic                     pop,
  output logic                     full,
  output logic                     not_empty,
  output logic [tcwi_pkg::SUM_W-1:0] head
);
  import tcwi_pkg::*;

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = PTR_W + 1;

  logic [SUM_W-1:0]  entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;
  logic              do_pop;

  assign full      = fill == FILL_W'(QUEUE_DEPTH);
  assign not_empty = fill != '0;
  assign head      = entries[rd_ptr];
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (push.valid) begin
      entries[wr_ptr] <= push.sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      case ({push.valid, do_pop})
        2'b10:   fill <= fill + FILL_W'(1);
        2'b01:   fill <= fill - FILL_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

// File: rtl/tcwi_back.sv
`timescale 1ns / 1ps
// Back end: divide each group sum, classify, track swaps and drive the result register.
// Depends on tcwi_pkg.
module tcwi_back (
  input  logic                       clk,
  input  logic                       rst,
  input  tcwi_pkg::tcwi_cfg_t        cfg,
  input  logic                       queue_not_empty,
  input  logic [tcwi_pkg::SUM_W-1:0] queue_head,
  output logic                       queue_pop,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [tcwi_pkg::AVG_W-1:0] out_average,
  output logic [1:0]                 out_tilt_state,
  output logic [tcwi_pkg::DUTY_W-1:0] out_servo_duty
);
  import tcwi_pkg::*;

  logic [PROD_W-1:0] prod;
  logic              s1_valid;
  logic [AVG_W-1:0]  s1_avg;
  logic              out_free;
  logic              s1_adv;

  logic [1:0] prev_direction;
  logic [3:0] swap_count;
  logic [5:0] quiet_count;

  logic [1:0]        dir;
  logic              swap;
  logic [3:0]        swap_next;
  logic [5:0]        quiet_next;
  logic              unstable;
  logic [1:0]        state_next;
  logic [DUTY_W-1:0] duty_next;

  assign out_free  = !out_valid || out_ready;
  assign s1_adv    = !s1_valid || out_free;
  assign queue_pop = s1_adv && queue_not_empty;
  assign prod      = PROD_W'(queue_head) * PROD_W'(RECIP);

  // Stage one: quotient by reciprocal multiply.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= queue_not_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (queue_pop) begin
      s1_avg <= prod[RECIP_SHIFT +: AVG_W];
    end
  end

  // Stage two: classification against the thresholds and swap tracking.
  always_comb begin
    if ({1'b0, s1_avg} < cfg.left_below) begin
      dir = DIR_LEFT;
    end else if (s1_avg > cfg.right_above) begin
      dir = DIR_RIGHT;
    end else if (s1_avg >= cfg.flat_floor && s1_avg <= cfg.flat_ceiling) begin
      dir = DIR_FLAT;
    end else begin
      dir = prev_direction;
    end

    swap = (prev_direction == DIR_LEFT && dir == DIR_RIGHT) ||
           (prev_direction == DIR_RIGHT && dir == DIR_LEFT);

    if (swap) begin
      swap_next  = (swap_count < SWAP_MAX) ? swap_count + 4'd1 : swap_count;
      quiet_next = '0;
    end else if (quiet_count < cfg.quiet_limit) begin
      swap_next  = swap_count;
      quiet_next = quiet_count + 6'd1;
    end else begin
      swap_next  = '0;
      quiet_next = quiet_count;
    end

    unstable = swap_next >= cfg.swaps_needed;
    if (unstable) begin
      state_next = TS_UNSTABLE;
      swap_next  = '0;
      quiet_next = '0;
    end else if (dir == DIR_LEFT) begin
      state_next = TS_LEFT;
    end else if (dir == DIR_RIGHT) begin
      state_next = TS_RIGHT;
    end else begin
      state_next = TS_FLAT;
    end

    case (state_next)
      TS_LEFT:  duty_next = cfg.inverted ? DUTY_RIGHT : DUTY_LEFT;
      TS_RIGHT: duty_next = cfg.inverted ? DUTY_LEFT : DUTY_RIGHT;
      default:  duty_next = DUTY_CENTRE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      prev_direction <= DIR_NONE;
      swap_count     <= '0;
      quiet_count    <= '0;
    end else if (out_free) begin
      out_valid <= s1_valid;
      if (s1_valid) begin
        prev_direction <= dir;
        swap_count     <= swap_next;
        quiet_count    <= quiet_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      out_average    <= s1_avg;
      out_tilt_state <= state_next;
      out_servo_duty <= duty_next;
    end
  end

endmodule

// File: rtl/tilt_classifier_with_instability_core.sv
`timescale 1ns / 1ps
// Top level of the tilt classifier: configuration registers, front end, queue, back end.
// Depends on tcwi_pkg, tcwi_if, tcwi_front, tcwi_queue and tcwi_back.
//
//   channel   dir   handshake          payload
//   samples   in    valid / ready      sample[11:0]
//   results   out   valid / ready      average[11:0], tilt_state[1:0], servo_duty[9:0]
//   apb       in    psel/penable/pwrite, pready always high   paddr[4:0], pwdata[31:0]
//
// One sample transaction per cycle is taken while the queue is not full. Each group of
// GROUP_SIZE samples gives one result. The edge that takes its last sample writes the
// group sum into the queue; the reciprocal multiply is registered into stage one, and
// the classification into the output register. The queue holds four group sums, so
// samples keep flowing while results stall; ready drops only when the queue is full.
// Reset is synchronous and restores the register defaults and clears all counters and
// the direction history.
module tilt_classifier_with_instability_core (
  input  logic        clk,
  input  logic        rst,
  tcwi_sample_if.sink samples,
  tcwi_result_if.source results,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tcwi_pkg::*;

  tcwi_cfg_t        cfg;
  tcwi_reg_t        reg_sel;
  logic             cfg_write;
  tcwi_push_t       push;
  logic             queue_full;
  logic             queue_not_empty;
  logic             queue_pop;
  logic [SUM_W-1:0] queue_head;

  // Configuration port: registers are word-aligned, index taken from paddr[4:2].
  assign pready    = 1'b1;
  assign reg_sel   = tcwi_reg_t'(paddr[4:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.left_below   <= 13'd1188;
      cfg.right_above  <= 12'd1515;
      cfg.flat_floor   <= 12'd1311;
      cfg.flat_ceiling <= 12'd1409;
      cfg.swaps_needed <= 4'd3;
      cfg.quiet_limit  <= 6'd35;
      cfg.inverted     <= 1'b0;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_LEFT_BELOW:   cfg.left_below   <= pwdata[12:0];
        REG_RIGHT_ABOVE:  cfg.right_above  <= pwdata[11:0];
        REG_FLAT_FLOOR:   cfg.flat_floor   <= pwdata[11:0];
        REG_FLAT_CEILING: cfg.flat_ceiling <= pwdata[11:0];
        REG_SWAPS_NEEDED: cfg.swaps_needed <= pwdata[3:0];
        REG_QUIET_LIMIT:  cfg.quiet_limit  <= pwdata[5:0];
        REG_INVERTED:     cfg.inverted     <= pwdata[0];
        default:          ;   // drop writes to the unused slot
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_LEFT_BELOW:   prdata = {19'd0, cfg.left_below};
      REG_RIGHT_ABOVE:  prdata = {20'd0, cfg.right_above};
      REG_FLAT_FLOOR:   prdata = {20'd0, cfg.flat_floor};
      REG_FLAT_CEILING: prdata = {20'd0, cfg.flat_ceiling};
      REG_SWAPS_NEEDED: prdata = {28'd0, cfg.swaps_needed};
      REG_QUIET_LIMIT:  prdata = {26'd0, cfg.quiet_limit};
      REG_INVERTED:     prdata = {31'd0, cfg.inverted};
      default:          prdata = '0;
    endcase
  end

  // Accumulate samples; hand each finished group sum to the queue.
  tcwi_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (samples.valid),
    .in_sample  (samples.sample),
    .queue_full (queue_full),
    .in_ready   (samples.ready),
    .push       (push)
  );

  // Decouple sample intake from result stalls.
  tcwi_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (queue_pop),
    .full      (queue_full),
    .not_empty (queue_not_empty),
    .head      (queue_head)
  );

  // Divide, classify, track swaps, and hold the result until it is taken.
  tcwi_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .queue_not_empty (queue_not_empty),
    .queue_head      (queue_head),
    .queue_pop       (queue_pop),
    .out_ready       (results.ready),
    .out_valid       (results.valid),
    .out_average     (results.average),
    .out_tilt_state  (results.tilt_state),
    .out_servo_duty  (results.servo_duty)
  );

endmodule

// File: rtl/tcwi_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the tilt classifier, attached to the top level by bind.
// Depends on tcwi_pkg and tilt_classifier_with_instability_core.
module tcwi_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [11:0] out_average,
  input logic [1:0]  out_tilt_state,
  input logic [9:0]  out_servo_duty,
  input logic        pready
);
  import tcwi_pkg::*;

  a_idle_after_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid straight after reset");

  a_centre_duty: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_tilt_state == TS_FLAT || out_tilt_state == TS_UNSTABLE)
    |-> out_servo_duty == DUTY_CENTRE)
    else $error("flat or unstable result without centre duty");

  a_side_duty: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_tilt_state == TS_LEFT || out_tilt_state == TS_RIGHT)
    |-> (out_servo_duty == DUTY_LEFT || out_servo_duty == DUTY_RIGHT))
    else $error("left or right result with centre or unknown duty");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_average)
    && $stable(out_tilt_state) && $stable(out_servo_duty))
    else $error("stalled result transaction changed");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready dropped");

endmodule

bind tilt_classifier_with_instability_core tcwi_checker u_tcwi_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (results.valid),
  .out_ready      (results.ready),
  .out_average    (results.average),
  .out_tilt_state (results.tilt_state),
  .out_servo_duty (results.servo_duty),
  .pready         (pready)
);
